// ===== src/sorted_wakeup_timer_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted wakeup timer queue
// Shared helpers that wrap a clocked implication in a labeled assertion.
// ----------------------------------------------------------------------------
`ifndef SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH
`define SORTED_WAKEUP_TIMER_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWTQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swtq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swtq assertion failed");

`endif

// ===== src/swtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue package
// Field widths, operation and status codes, and the item types shared by
// the channel interface and the modules of the queue.
// ----------------------------------------------------------------------------
package swtq_pkg;

   localparam int TICK_W      = 63;
   localparam int ID_W        = 8;
   // A single tick item releases at most this many threads.
   localparam int MAX_RESULTS = 16;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef enum logic {
      OP_SLEEP = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   // Input item as seen on the request channel.
   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   thread_id;
      logic [TICK_W-1:0] tick_value;
   } req_type;

   // Result item as seen on the response channel.
   typedef struct packed {
      logic [ID_W-1:0]   woken_id;
      logic              woke;
      status_type        status;
      logic [TICK_W-1:0] next_wake;
      logic              last;
   } rsp_type;

   // Decoded command held in the front queue.
   typedef struct packed {
      logic              is_tick;
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] tick;
   } cmd_type;

   // Controls from the sequencer to the row of slot cells.
   typedef struct packed {
      logic cmp_en;
      logic insert;
      logic pop;
   } cell_ctl_type;

endpackage

// ===== src/swtq_chan_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// One item moves at a rising clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface swtq_chan_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== src/swtq_front.sv =====
// ----------------------------------------------------------------------------
// Front end of the sorted wakeup timer queue
// Accepts request items, decodes the operation and holds up to two
// commands for the back end in a small queue.
// ----------------------------------------------------------------------------
module swtq_front (
   input  logic                  clock,
   input  logic                  reset,
   swtq_chan_if.sink             req_if,
   output logic                  cmd_valid,
   output swtq_pkg::cmd_type     cmd,
   input  logic                  cmd_pop
);

   localparam int FIFO_DEPTH = 2;
   localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic              wr_ptr_ff, wr_ptr_in;
   swtq_pkg::cmd_type entry_ff [FIFO_DEPTH];
   swtq_pkg::cmd_type decoded;
   logic              push;
   logic              pop;

   // Decode the request into a command.
   always_comb begin
      decoded.is_tick = (req_if.data.op == swtq_pkg::OP_TICK);
      decoded.id      = req_if.data.thread_id;
      decoded.tick    = req_if.data.tick_value;
   end

   assign req_if.ready = (fill_ff != FILL_W'(FIFO_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign cmd_valid    = (fill_ff != '0);
   assign pop          = cmd_pop && cmd_valid;
   assign cmd          = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== src/swtq_cells.sv =====
// ----------------------------------------------------------------------------
// Slot cells of the sorted wakeup timer queue
// A row of cells kept in ascending tick order. Each cell compares its own
// tick with the command tick; an insert shifts the later cells up by one
// and a pop shifts every cell down by one.
// ----------------------------------------------------------------------------
module swtq_cells #(
   parameter  int QUEUE_DEPTH = 16,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  swtq_pkg::cell_ctl_type        ctl,
   input  swtq_pkg::cmd_type             cmd,
   input  logic [CNT_W-1:0]              count,
   input  logic [QUEUE_DEPTH-1:0]        sel,
   output logic [QUEUE_DEPTH-1:0]        gt_ff,
   output logic [swtq_pkg::ID_W-1:0]     head_id,
   output logic [swtq_pkg::TICK_W-1:0]   pick_tick
);

   logic [swtq_pkg::TICK_W-1:0] tick_ff [QUEUE_DEPTH];
   logic [swtq_pkg::ID_W-1:0]   id_ff   [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]      gt_in;
   logic [QUEUE_DEPTH:0]        gt_prev;

   // Bit i of gt_prev is the compare result of the cell below cell i.
   assign gt_prev = {gt_ff, 1'b0};

   // An empty cell counts as later than any tick.
   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         gt_ff <= gt_in;
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [swtq_pkg::TICK_W-1:0] up_tick;
      logic [swtq_pkg::ID_W-1:0]   up_id;
      logic [swtq_pkg::TICK_W-1:0] down_tick;
      logic [swtq_pkg::ID_W-1:0]   down_id;

      if (i == 0) begin : g_first
         assign up_tick = cmd.tick;
         assign up_id   = cmd.id;
      end else begin : g_inner
         assign up_tick = tick_ff[i-1];
         assign up_id   = id_ff[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign down_tick = tick_ff[i];
         assign down_id   = id_ff[i];
      end else begin : g_below
         assign down_tick = tick_ff[i+1];
         assign down_id   = id_ff[i+1];
      end

      assign gt_in[i] = (CNT_W'(i) >= count) || (tick_ff[i] > cmd.tick);

      // A cell past the insert point takes its lower neighbor, the cell at
      // the insert point takes the new entry, and a pop shifts down.
      always_ff @(posedge clock) begin
         if (ctl.insert && gt_ff[i]) begin
            if (gt_prev[i]) begin
               tick_ff[i] <= up_tick;
               id_ff[i]   <= up_id;
            end else begin
               tick_ff[i] <= cmd.tick;
               id_ff[i]   <= cmd.id;
            end
         end else if (ctl.pop) begin
            tick_ff[i] <= down_tick;
            id_ff[i]   <= down_id;
         end
      end
   end

   assign head_id = id_ff[0];

   // One-hot pick of the tick that becomes the new head.
   always_comb begin
      pick_tick = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         pick_tick = pick_tick | ({swtq_pkg::TICK_W{sel[i]}} & tick_ff[i]);
      end
   end

endmodule

// ===== src/swtq_back.sv =====
// ----------------------------------------------------------------------------
// Back end of the sorted wakeup timer queue
// Sequences one command at a time: compare against the slot cells, then
// insert or release entries, and drive the registered response channel.
// ----------------------------------------------------------------------------
module swtq_back #(
   parameter  int QUEUE_DEPTH = 16,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  swtq_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output swtq_pkg::cell_ctl_type        ctl,
   output swtq_pkg::cmd_type             cur_cmd,
   output logic [CNT_W-1:0]              count,
   input  logic [QUEUE_DEPTH-1:0]        gt_ff,
   input  logic [swtq_pkg::ID_W-1:0]     head_id,
   output logic [QUEUE_DEPTH-1:0]        sel,
   input  logic [swtq_pkg::TICK_W-1:0]   pick_tick,
   swtq_chan_if.source                   rsp_if
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_INS,
      ST_SEL,
      ST_POP
   } state_type;

   state_type                   state_ff, state_in;
   swtq_pkg::cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [swtq_pkg::TICK_W-1:0] earliest_ff, earliest_in;
   logic [QUEUE_DEPTH:0]        take_ff, take_in;
   swtq_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [QUEUE_DEPTH:0]        take;
   logic [QUEUE_DEPTH:0]        take_prev;
   logic                        out_free;
   logic                        full;

   assign cur_cmd      = cmd_ff;
   assign count        = count_ff;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_ff;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign full         = (count_ff == CNT_W'(QUEUE_DEPTH));

   // Entries due for release form a prefix, capped at the result limit.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         take[i] = !gt_ff[i] && (i < swtq_pkg::MAX_RESULTS);
      end
      take[QUEUE_DEPTH] = 1'b0;
   end

   // The first entry left after the release becomes the new head.
   assign take_prev = {take[QUEUE_DEPTH-1:0], 1'b1};
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel[i] = take_prev[i] && !take[i] && (CNT_W'(i) < count_ff);
      end
   end

   // Sequencer next-state and response logic.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      earliest_in  = earliest_ff;
      take_in      = take_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      cmd_pop      = 1'b0;
      ctl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            ctl.cmp_en = 1'b1;
            state_in   = cmd_ff.is_tick ? ST_SEL : ST_INS;
         end
         ST_INS: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.woken_id = '0;
               rsp_in.woke     = 1'b0;
               rsp_in.last     = 1'b1;
               if (full) begin
                  rsp_in.status    = swtq_pkg::STATUS_FULL;
                  rsp_in.next_wake = earliest_ff;
               end else begin
                  ctl.insert       = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
                  // The new entry becomes the head when every held entry is later.
                  earliest_in      = gt_ff[0] ? cmd_ff.tick : earliest_ff;
                  rsp_in.status    = swtq_pkg::STATUS_OK;
                  rsp_in.next_wake = earliest_in;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SEL: begin
            take_in     = take;
            earliest_in = (|sel) ? pick_tick : swtq_pkg::TICK_MAX;
            state_in    = ST_POP;
         end
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.woken_id  = take_ff[0] ? head_id : '0;
               rsp_in.woke      = take_ff[0];
               rsp_in.status    = swtq_pkg::STATUS_OK;
               rsp_in.next_wake = earliest_ff;
               rsp_in.last      = !take_ff[1];
               if (take_ff[0]) begin
                  ctl.pop  = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  take_in  = take_ff >> 1;
               end
               if (!take_ff[1]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         earliest_ff  <= swtq_pkg::TICK_MAX;
         take_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         earliest_ff  <= earliest_in;
         take_ff      <= take_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== src/sorted_wakeup_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted wakeup timer queue
// Holds sleeping threads sorted by wakeup tick and releases the due threads, up
// to the result limit, on a timer tick, one response item per released thread.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload                                   Handshake
//   req_if    in         op, thread_id, tick_value                 valid/ready
//   rsp_if    out        woken_id, woke, status, next_wake, last   valid/ready
//
// A sleep item passes load, compare and insert in the back end. A tick item
// passes load, compare and select, then gives one result per released thread
// (at least one result), the slot cells shifting one entry down per cycle; a
// stalled response holds the back end in place. A two-entry command queue
// lets requests be accepted while the back end works. Reset is synchronous;
// after reset the queue is empty and the held earliest tick is the maximum.
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic         clock,
   input logic         reset,
   swtq_chan_if.sink   req_if,
   swtq_chan_if.source rsp_if
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                        cmd_valid;
   swtq_pkg::cmd_type           cmd;
   logic                        cmd_pop;
   swtq_pkg::cell_ctl_type      ctl;
   swtq_pkg::cmd_type           cur_cmd;
   logic [CNT_W-1:0]            count;
   logic [QUEUE_DEPTH-1:0]      gt_ff;
   logic [swtq_pkg::ID_W-1:0]   head_id;
   logic [QUEUE_DEPTH-1:0]      sel;
   logic [swtq_pkg::TICK_W-1:0] pick_tick;

   // Request decode and command queue.
   swtq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Sequencer and response register.
   swtq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .ctl       (ctl),
      .cur_cmd   (cur_cmd),
      .count     (count),
      .gt_ff     (gt_ff),
      .head_id   (head_id),
      .sel       (sel),
      .pick_tick (pick_tick),
      .rsp_if    (rsp_if)
   );

   // Sorted slot storage.
   swtq_cells #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_cells (
      .clock     (clock),
      .ctl       (ctl),
      .cmd       (cur_cmd),
      .count     (count),
      .sel       (sel),
      .gt_ff     (gt_ff),
      .head_id   (head_id),
      .pick_tick (pick_tick)
   );

endmodule

// ===== src/swtq_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the sorted wakeup timer queue
// Watches the response channel for framing and handshake slips.
// ----------------------------------------------------------------------------
`include "sorted_wakeup_timer_queue_assert.svh"

module swtq_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_woke,
   input logic rsp_status,
   input logic rsp_last
);

   // A stalled response item stays offered.
   `SWTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A dropped insert is a single, final item that releases nobody.
   `SWTQ_ASSERT_IMPL(a_full_single, clock, reset, rsp_valid && rsp_status, rsp_last && !rsp_woke)

   // An item that releases nobody always closes its group.
   `SWTQ_ASSERT_IMPL(a_idle_last, clock, reset, rsp_valid && !rsp_woke, rsp_last)

   // Nothing is offered right after reset.
   `SWTQ_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind sorted_wakeup_timer_queue swtq_checker u_swtq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_woke   (rsp_if.data.woke),
   .rsp_status (rsp_if.data.status),
   .rsp_last   (rsp_if.data.last)
);
